[hw/rtl/wavelength_to_rgb_unit_defines.svh]
// ----------------------------------------------------------------------------
// Wavelength to RGB assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAVELENGTH_TO_RGB_UNIT_DEFINES_SVH
`define WAVELENGTH_TO_RGB_UNIT_DEFINES_SVH

// Same-cycle implication.
`define W2RGB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wavelength_to_rgb_unit: same-cycle check failed");

// Next-cycle implication.
`define W2RGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wavelength_to_rgb_unit: next-cycle check failed");

`endif

[hw/rtl/w2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// Wavelength to RGB package
// Widths, hue segment codes, per-segment constants and pipeline enables.
// ----------------------------------------------------------------------------
package w2rgb_pkg;

	localparam int WL_W    = 10;  // wavelength width
	localparam int CN_W    = 7;   // channel numerator, at most 70
	localparam int INT_W   = 10;  // intensity numerator over 800
	localparam int PROD_W  = 16;  // numerator times intensity, at most 56000
	localparam int SUM_W   = 22;  // scaled and biased sum
	localparam int QUOT_W  = 17;  // sum divided by 32
	localparam int RECIP_W = 24;  // reciprocal constant width
	localparam int RECIP_K = 26;  // reciprocal shift
	localparam int MUL_W   = QUOT_W + RECIP_W;
	localparam int CH_W    = 8;

	localparam logic [2:0] SEG_VIOLET = 3'd0;  // 380 to 440
	localparam logic [2:0] SEG_BLUE   = 3'd1;  // up to 490
	localparam logic [2:0] SEG_CYAN   = 3'd2;  // up to 510
	localparam logic [2:0] SEG_GREEN  = 3'd3;  // up to 580
	localparam logic [2:0] SEG_ORANGE = 3'd4;  // up to 645
	localparam logic [2:0] SEG_RED    = 3'd5;  // up to 780

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// Segment denominator of the channel fraction.
	function automatic logic [CN_W-1:0] seg_den(input logic [2:0] seg);
		logic [CN_W-1:0] d;
		unique case (seg)
			SEG_VIOLET: d = 7'd60;
			SEG_BLUE:   d = 7'd50;
			SEG_CYAN:   d = 7'd20;
			SEG_GREEN:  d = 7'd70;
			SEG_ORANGE: d = 7'd65;
			default:    d = 7'd1;
		endcase
		return d;
	endfunction

	// ceil(2^26 / (5 * den)); exact floor division for quotients below 2^17.
	function automatic logic [RECIP_W-1:0] seg_recip(input logic [2:0] seg);
		logic [RECIP_W-1:0] m;
		unique case (seg)
			SEG_VIOLET: m = 24'd223697;
			SEG_BLUE:   m = 24'd268436;
			SEG_CYAN:   m = 24'd671089;
			SEG_GREEN:  m = 24'd191740;
			SEG_ORANGE: m = 24'd206489;
			default:    m = 24'd13421773;
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/w2rgb_decode.sv]
// ----------------------------------------------------------------------------
// Wavelength to RGB segment decode
// First stage: picks the hue segment, the three channel numerators and the
// intensity numerator, and registers them.
// ----------------------------------------------------------------------------
module w2rgb_decode (
	input  logic                              clk,
	input  logic                              en,
	input  logic [w2rgb_pkg::WL_W-1:0]        wavelength_nm,
	output logic [2:0]                        seg_s1,
	output logic [w2rgb_pkg::CN_W-1:0]        rn_s1,
	output logic [w2rgb_pkg::CN_W-1:0]        gn_s1,
	output logic [w2rgb_pkg::CN_W-1:0]        bn_s1,
	output logic [w2rgb_pkg::INT_W-1:0]       inten_s1
);

	logic                           black;
	logic [2:0]                     seg;
	logic [w2rgb_pkg::CN_W-1:0]     rn, gn, bn;
	logic [w2rgb_pkg::INT_W-1:0]    inten;
	logic [w2rgb_pkg::WL_W-1:0]     d440, d_w440, d510, d_w510, d645, d780, d_w380;

	assign d440   = 10'd440 - wavelength_nm;
	assign d_w440 = wavelength_nm - 10'd440;
	assign d510   = 10'd510 - wavelength_nm;
	assign d_w510 = wavelength_nm - 10'd510;
	assign d645   = 10'd645 - wavelength_nm;
	assign d780   = 10'd780 - wavelength_nm;
	assign d_w380 = wavelength_nm - 10'd380;

	assign black = (wavelength_nm < 10'd380) || (wavelength_nm > 10'd780);

	always_comb begin
		if (wavelength_nm <= 10'd440) begin
			seg = w2rgb_pkg::SEG_VIOLET;
			rn  = d440[w2rgb_pkg::CN_W-1:0];
			gn  = '0;
			bn  = 7'd60;
		end else if (wavelength_nm <= 10'd490) begin
			seg = w2rgb_pkg::SEG_BLUE;
			rn  = '0;
			gn  = d_w440[w2rgb_pkg::CN_W-1:0];
			bn  = 7'd50;
		end else if (wavelength_nm <= 10'd510) begin
			seg = w2rgb_pkg::SEG_CYAN;
			rn  = '0;
			gn  = 7'd20;
			bn  = d510[w2rgb_pkg::CN_W-1:0];
		end else if (wavelength_nm <= 10'd580) begin
			seg = w2rgb_pkg::SEG_GREEN;
			rn  = d_w510[w2rgb_pkg::CN_W-1:0];
			gn  = 7'd70;
			bn  = '0;
		end else if (wavelength_nm <= 10'd645) begin
			seg = w2rgb_pkg::SEG_ORANGE;
			rn  = 7'd65;
			gn  = d645[w2rgb_pkg::CN_W-1:0];
			bn  = '0;
		end else begin
			seg = w2rgb_pkg::SEG_RED;
			rn  = 7'd1;
			gn  = '0;
			bn  = '0;
		end

		if (wavelength_nm >= 10'd700) begin
			inten = 10'd240 + 10'(d780 * 10'd7);
		end else if (wavelength_nm < 10'd420) begin
			inten = 10'd240 + 10'(d_w380 * 10'd14);
		end else begin
			inten = 10'd800;
		end

		// Out of band: zero numerators round to zero in every segment.
		if (black) begin
			rn = '0;
			gn = '0;
			bn = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1   <= seg;
			rn_s1    <= rn;
			gn_s1    <= gn;
			bn_s1    <= bn;
			inten_s1 <= inten;
		end
	end

endmodule

[hw/rtl/w2rgb_chan.sv]
// ----------------------------------------------------------------------------
// Wavelength to RGB channel scaler
// Stages two to four of one channel: numerator times intensity, scale by 255
// with the rounding bias, then divide by the segment denominator through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module w2rgb_chan (
	input  logic                              clk,
	input  w2rgb_pkg::pipe_en_t               en,
	input  logic [2:0]                        seg_s1,
	input  logic [w2rgb_pkg::CN_W-1:0]        cn_s1,
	input  logic [w2rgb_pkg::INT_W-1:0]       inten_s1,
	output logic [w2rgb_pkg::CH_W-1:0]        chan_s4
);

	logic [2:0]                       seg_s2, seg_s3;
	logic [w2rgb_pkg::PROD_W-1:0]     prod_s2;
	logic [w2rgb_pkg::QUOT_W-1:0]     quot_s3;
	logic [w2rgb_pkg::SUM_W-1:0]      sum;
	logic [w2rgb_pkg::MUL_W-1:0]      mul;

	// Round half up: (p * 255 + 400 * den) / (800 * den), reduced by 5.
	assign sum = w2rgb_pkg::SUM_W'(prod_s2) * w2rgb_pkg::SUM_W'(51)
		+ w2rgb_pkg::SUM_W'(w2rgb_pkg::seg_den(seg_s2)) * w2rgb_pkg::SUM_W'(80);

	assign mul = w2rgb_pkg::MUL_W'(quot_s3)
		* w2rgb_pkg::MUL_W'(w2rgb_pkg::seg_recip(seg_s3));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2  <= seg_s1;
			prod_s2 <= w2rgb_pkg::PROD_W'(cn_s1) * w2rgb_pkg::PROD_W'(inten_s1);
		end
		if (en.s3) begin
			seg_s3  <= seg_s2;
			quot_s3 <= sum[w2rgb_pkg::SUM_W-1:5];
		end
		if (en.s4) begin
			chan_s4 <= mul[w2rgb_pkg::RECIP_K+w2rgb_pkg::CH_W-1:w2rgb_pkg::RECIP_K];
		end
	end

endmodule

[hw/rtl/wavelength_to_rgb_unit.sv]
// ----------------------------------------------------------------------------
// Wavelength to RGB unit
// Converts a wavelength in nanometres into an 8-bit red, green, blue triple.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while in_stall is low and returns its
// color through a four-stage pipeline: segment decode, numerator times
// intensity, scaling with the rounding bias, and a reciprocal multiply that
// divides by the segment denominator. Each stage holds its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close up
// under output stall and a new request is taken while a finished color waits.
// Wavelengths below 380 or above 780 give black.
`include "wavelength_to_rgb_unit_defines.svh"

module wavelength_to_rgb_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [w2rgb_pkg::WL_W-1:0]        wavelength_nm,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [w2rgb_pkg::CH_W-1:0]        red,
	output logic [w2rgb_pkg::CH_W-1:0]        green,
	output logic [w2rgb_pkg::CH_W-1:0]        blue
);

	w2rgb_pkg::pipe_en_t              en;
	logic                             v_s1, v_s2, v_s3, v_s4;
	logic [2:0]                       seg_s1;
	logic [w2rgb_pkg::CN_W-1:0]       rn_s1, gn_s1, bn_s1;
	logic [w2rgb_pkg::INT_W-1:0]      inten_s1;

	assign en.s4 = !v_s4 || !out_stall;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_stall  = !en.s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	w2rgb_decode u_decode (
		.clk           (clk),
		.en            (en.s1),
		.wavelength_nm (wavelength_nm),
		.seg_s1        (seg_s1),
		.rn_s1         (rn_s1),
		.gn_s1         (gn_s1),
		.bn_s1         (bn_s1),
		.inten_s1      (inten_s1)
	);

	w2rgb_chan u_red (
		.clk      (clk),
		.en       (en),
		.seg_s1   (seg_s1),
		.cn_s1    (rn_s1),
		.inten_s1 (inten_s1),
		.chan_s4  (red)
	);

	w2rgb_chan u_green (
		.clk      (clk),
		.en       (en),
		.seg_s1   (seg_s1),
		.cn_s1    (gn_s1),
		.inten_s1 (inten_s1),
		.chan_s4  (green)
	);

	w2rgb_chan u_blue (
		.clk      (clk),
		.en       (en),
		.seg_s1   (seg_s1),
		.cn_s1    (bn_s1),
		.inten_s1 (inten_s1),
		.chan_s4  (blue)
	);

	// The input is held off only when every stage is occupied.
	`W2RGB_ASSERT_SAME(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4)
	// An accepted request lands in the first stage.
	`W2RGB_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v_s1)
	// A request in the third stage moves to the output when it is free.
	`W2RGB_ASSERT_NEXT(a_s3_advances, v_s3 && !out_stall, v_s4)

endmodule
